// ===== hdl/tlsfa_pkg.sv =====
// Shared constants, types and helper functions of the slot and fragment allocator.
package tlsfa_pkg;

    localparam int NUM_FRAGMENTS      = 512;
    localparam int SLOTS_PER_FRAGMENT = 64;
    localparam int FRAG_W    = $clog2(NUM_FRAGMENTS);
    localparam int WORD_W    = 32;
    localparam int BIT_W     = 5;
    localparam int NUM_WORDS = (NUM_FRAGMENTS + WORD_W - 1) / WORD_W;
    localparam int WIDX_W    = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;

    localparam logic [1:0] MODE_SLOT  = 2'd0;
    localparam logic [1:0] MODE_WHOLE = 2'd1;
    localparam logic [1:0] MODE_FREE  = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NOSPACE = 2'd1;
    localparam logic [1:0] ST_INVALID = 2'd2;

    typedef enum logic [2:0] {
        OP_ALLOC,
        OP_WHOLE,
        OP_FREE,
        OP_NOSPACE,
        OP_BADFREE,
        OP_BADMODE
    } op_t;

    typedef struct packed {
        logic load;
        logic find;
        logic commit;
        logic clear_step;
    } dp_cmd_t;

    typedef struct packed {
        logic clear_done;
        logic out_busy;
    } dp_stat_t;

    // Bits of a summary word that stand for real fragments.
    function automatic logic [WORD_W-1:0] word_mask(input logic [WIDX_W-1:0] widx);
        logic [WORD_W-1:0] m;
        m = '0;
        for (int i = 0; i < WORD_W; i++)
        begin
            m[i] = ((int'(widx) * WORD_W + i) < NUM_FRAGMENTS);
        end
        return m;
    endfunction

    function automatic logic [BIT_W-1:0] penc_word(input logic [WORD_W-1:0] v);
        logic [BIT_W-1:0] r;
        r = '0;
        for (int i = WORD_W - 1; i >= 0; i--)
        begin
            if (v[i])
            begin
                r = BIT_W'(i);
            end
        end
        return r;
    endfunction

    function automatic logic [WIDX_W-1:0] penc_words(input logic [NUM_WORDS-1:0] v);
        logic [WIDX_W-1:0] r;
        r = '0;
        for (int i = NUM_WORDS - 1; i >= 0; i--)
        begin
            if (v[i])
            begin
                r = WIDX_W'(i);
            end
        end
        return r;
    endfunction

    function automatic logic [5:0] penc_slots(input logic [SLOTS_PER_FRAGMENT-1:0] v);
        logic [5:0] r;
        r = '0;
        for (int i = SLOTS_PER_FRAGMENT - 1; i >= 0; i--)
        begin
            if (v[i])
            begin
                r = 6'(i);
            end
        end
        return r;
    endfunction

endpackage

// ===== hdl/tlsfa_req_if.sv =====
// Request channel of the allocator.
interface tlsfa_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] mode;
    logic [8:0] free_fragment;
    logic [5:0] free_slot;

    modport source (output valid, mode, free_fragment, free_slot, input ready);
    modport sink (input valid, mode, free_fragment, free_slot, output ready);
endinterface

// ===== hdl/tlsfa_rsp_if.sv =====
// Response channel of the allocator.
interface tlsfa_rsp_if;
    logic       valid;
    logic       ready;
    logic [1:0] status;
    logic [8:0] granted_fragment;
    logic [5:0] granted_slot;

    modport source (output valid, status, granted_fragment, granted_slot, input ready);
    modport sink (input valid, status, granted_fragment, granted_slot, output ready);
endinterface

// ===== hdl/two_level_slot_fragment_allocator_core.sv =====
// Top level of the two-level slot and fragment allocator.
// After reset the block clears its fragment memory, one entry a cycle, for all
// NUM_FRAGMENTS (512) entries, and takes no request until that pass is done. Each request
// then passes a find state, which picks the target fragment from the per-word summary
// bitmaps and reads its entry from the fragment memory, and a modify state, which updates
// the entry and summaries and loads the response register once any earlier response
// is taken. A new request is taken in the cycle that a response is loaded.
module two_level_slot_fragment_allocator_core (
    input logic        clk,
    input logic        rst_n,
    tlsfa_req_if.sink  req,
    tlsfa_rsp_if.source rsp
);

    tlsfa_pkg::dp_cmd_t  cmd;
    tlsfa_pkg::dp_stat_t stat;

    tlsfa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    tlsfa_dp u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .stat             (stat),
        .mode             (req.mode),
        .free_fragment    (req.free_fragment),
        .free_slot        (req.free_slot),
        .rsp_valid        (rsp.valid),
        .rsp_ready        (rsp.ready),
        .status           (rsp.status),
        .granted_fragment (rsp.granted_fragment),
        .granted_slot     (rsp.granted_slot)
    );

endmodule

// ===== hdl/tlsfa_ctrl.sv =====
// Controller state machine of the allocator.
module tlsfa_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_ready,
    input  tlsfa_pkg::dp_stat_t stat,
    output tlsfa_pkg::dp_cmd_t  cmd
);

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_FIND,
        S_MODIFY
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next     = state_reg;
        req_ready      = 1'b0;
        cmd.find       = 1'b0;
        cmd.commit     = 1'b0;
        cmd.clear_step = 1'b0;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (stat.clear_done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    state_next = S_FIND;
                end
            end
            S_FIND:
            begin
                cmd.find   = 1'b1;
                state_next = S_MODIFY;
            end
            S_MODIFY:
            begin
                if (!stat.out_busy)
                begin
                    cmd.commit = 1'b1;
                    req_ready  = 1'b1;
                    state_next = req_valid ? S_FIND : S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        cmd.load = req_valid && req_ready;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== hdl/tlsfa_dp.sv =====
// Datapath of the allocator: fragment memory, summary bitmaps and result register.
module tlsfa_dp (
    input  logic                clk,
    input  logic                rst_n,
    input  tlsfa_pkg::dp_cmd_t  cmd,
    output tlsfa_pkg::dp_stat_t stat,
    input  logic [1:0]          mode,
    input  logic [8:0]          free_fragment,
    input  logic [5:0]          free_slot,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output logic [1:0]          status,
    output logic [8:0]          granted_fragment,
    output logic [5:0]          granted_slot
);

    localparam int NF = tlsfa_pkg::NUM_FRAGMENTS;
    localparam int SL = tlsfa_pkg::SLOTS_PER_FRAGMENT;
    localparam int FW = tlsfa_pkg::FRAG_W;
    localparam int WW = tlsfa_pkg::WORD_W;
    localparam int NW = tlsfa_pkg::NUM_WORDS;
    localparam int XW = tlsfa_pkg::WIDX_W;
    localparam int BW = tlsfa_pkg::BIT_W;

    // Each entry holds the whole mark above the slot bitmap.
    logic [SL:0] mem [NF];
    logic [SL:0] rd_reg;

    logic [WW-1:0] part_word_reg  [NW];
    logic [WW-1:0] empty_word_reg [NW];
    logic [NW-1:0] part_any;
    logic [NW-1:0] empty_any;

    logic [1:0]    mode_reg;
    logic [8:0]    ffrag_reg;
    logic [5:0]    fslot_reg;
    tlsfa_pkg::op_t op_reg;
    tlsfa_pkg::op_t op_next;
    logic [XW-1:0] widx_reg;
    logic [XW-1:0] widx_next;
    logic [BW-1:0] bit_reg;
    logic [BW-1:0] bit_next;
    logic [8:0]    res_frag_next;
    logic [5:0]    res_slot_next;
    logic [FW-1:0] clear_cnt_reg;
    logic [FW-1:0] addr;

    logic          out_valid_reg;
    logic [1:0]    status_reg;
    logic [8:0]    frag_out_reg;
    logic [5:0]    slot_out_reg;
    logic [8:0]    res_frag_reg;
    logic [5:0]    res_slot_reg;

    logic          rd_whole;
    logic [SL-1:0] rd_bm;
    logic [SL-1:0] free_bits;
    logic [5:0]    alloc_slot;
    logic [SL-1:0] free_onehot;
    logic          free_ok;
    logic          wr_en;
    logic [SL:0]   wr_data;
    logic [SL-1:0] new_bm;
    logic          new_whole;
    logic [1:0]    commit_status;
    logic [5:0]    commit_slot;

    always_comb
    begin
        for (int i = 0; i < NW; i++)
        begin
            part_any[i]  = |part_word_reg[i];
            empty_any[i] = |empty_word_reg[i];
        end
    end

    // Slot mode: lowest partly filled, then lowest empty; whole mode: lowest empty.
    always_comb
    begin
        op_next       = tlsfa_pkg::OP_BADMODE;
        widx_next     = '0;
        bit_next      = '0;
        res_frag_next = '0;
        res_slot_next = '0;
        case (mode_reg)
            tlsfa_pkg::MODE_SLOT:
            begin
                if (|part_any)
                begin
                    op_next   = tlsfa_pkg::OP_ALLOC;
                    widx_next = tlsfa_pkg::penc_words(part_any);
                    bit_next  = tlsfa_pkg::penc_word(part_word_reg[widx_next]);
                end
                else if (|empty_any)
                begin
                    op_next   = tlsfa_pkg::OP_ALLOC;
                    widx_next = tlsfa_pkg::penc_words(empty_any);
                    bit_next  = tlsfa_pkg::penc_word(empty_word_reg[widx_next]);
                end
                else
                begin
                    op_next = tlsfa_pkg::OP_NOSPACE;
                end
            end
            tlsfa_pkg::MODE_WHOLE:
            begin
                if (|empty_any)
                begin
                    op_next   = tlsfa_pkg::OP_WHOLE;
                    widx_next = tlsfa_pkg::penc_words(empty_any);
                    bit_next  = tlsfa_pkg::penc_word(empty_word_reg[widx_next]);
                end
                else
                begin
                    op_next = tlsfa_pkg::OP_NOSPACE;
                end
            end
            tlsfa_pkg::MODE_FREE:
            begin
                res_slot_next = fslot_reg;
                if (int'(ffrag_reg) < NF && int'(fslot_reg) < SL)
                begin
                    op_next   = tlsfa_pkg::OP_FREE;
                    widx_next = XW'(ffrag_reg >> BW);
                    bit_next  = ffrag_reg[BW-1:0];
                end
                else
                begin
                    op_next       = tlsfa_pkg::OP_BADFREE;
                    res_frag_next = ffrag_reg;
                end
            end
            default:
            begin
                op_next = tlsfa_pkg::OP_BADMODE;
            end
        endcase
        if (op_next == tlsfa_pkg::OP_ALLOC || op_next == tlsfa_pkg::OP_WHOLE ||
            op_next == tlsfa_pkg::OP_FREE)
        begin
            res_frag_next = 9'(FW'({widx_next, bit_next}));
        end
    end

    assign rd_whole    = rd_reg[SL];
    assign rd_bm       = rd_reg[SL-1:0];
    assign free_bits   = ~rd_bm;
    assign alloc_slot  = tlsfa_pkg::penc_slots(free_bits);
    assign free_onehot = SL'(1) << fslot_reg;
    assign free_ok     = !rd_whole && ((rd_bm & free_onehot) != '0);

    always_comb
    begin
        wr_en         = 1'b0;
        new_whole     = rd_whole;
        new_bm        = rd_bm;
        commit_status = tlsfa_pkg::ST_OK;
        commit_slot   = res_slot_reg;
        case (op_reg)
            tlsfa_pkg::OP_ALLOC:
            begin
                wr_en       = 1'b1;
                new_bm      = rd_bm | (SL'(1) << alloc_slot);
                commit_slot = alloc_slot;
            end
            tlsfa_pkg::OP_WHOLE:
            begin
                wr_en     = 1'b1;
                new_whole = 1'b1;
            end
            tlsfa_pkg::OP_FREE:
            begin
                wr_en  = free_ok;
                new_bm = rd_bm & ~free_onehot;
                if (!free_ok)
                begin
                    commit_status = tlsfa_pkg::ST_INVALID;
                end
            end
            tlsfa_pkg::OP_NOSPACE:
            begin
                commit_status = tlsfa_pkg::ST_NOSPACE;
            end
            default:
            begin
                commit_status = tlsfa_pkg::ST_INVALID;
            end
        endcase
        wr_en   = wr_en && cmd.commit;
        wr_data = {new_whole, new_bm};
    end

    assign addr = cmd.clear_step ? clear_cnt_reg : FW'({widx_reg, bit_reg});

    always_ff @(posedge clk)
    begin
        if (cmd.clear_step || wr_en)
        begin
            mem[addr] <= cmd.clear_step ? '0 : wr_data;
        end
        if (cmd.find)
        begin
            rd_reg <= mem[FW'({widx_next, bit_next})];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NW; i++)
            begin
                part_word_reg[i]  <= '0;
                empty_word_reg[i] <= tlsfa_pkg::word_mask(XW'(i));
            end
            clear_cnt_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clear_step)
            begin
                clear_cnt_reg <= clear_cnt_reg + 1'b1;
            end
            if (wr_en)
            begin
                part_word_reg[widx_reg][bit_reg]  <= !new_whole && new_bm != '0 &&
                                                     new_bm != '1;
                empty_word_reg[widx_reg][bit_reg] <= !new_whole && new_bm == '0;
            end
            if (cmd.commit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mode_reg  <= mode;
            ffrag_reg <= free_fragment;
            fslot_reg <= free_slot;
        end
        if (cmd.find)
        begin
            op_reg       <= op_next;
            widx_reg     <= widx_next;
            bit_reg      <= bit_next;
            res_frag_reg <= res_frag_next;
            res_slot_reg <= res_slot_next;
        end
        if (cmd.commit)
        begin
            status_reg   <= commit_status;
            frag_out_reg <= res_frag_reg;
            slot_out_reg <= commit_slot;
        end
    end

    assign stat.clear_done = (clear_cnt_reg == FW'(NF - 1));
    assign stat.out_busy   = out_valid_reg && !rsp_ready;

    assign rsp_valid        = out_valid_reg;
    assign status           = status_reg;
    assign granted_fragment = frag_out_reg;
    assign granted_slot     = slot_out_reg;

    a_commit_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> rsp_valid)
        else $error("committed request did not produce a result");

    a_no_request_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clear_step |-> !cmd.load && !cmd.find)
        else $error("request taken during the clearing pass");

    a_alloc_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.commit && op_reg == tlsfa_pkg::OP_ALLOC) |-> (!rd_whole && free_bits != '0))
        else $error("slot allocation picked a fragment without a free slot");

    a_no_commit_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
        stat.out_busy |-> !cmd.commit)
        else $error("result overwritten before it was taken");

endmodule
